### hdl/bdq_pkg.sv
// bdq_pkg: shared types and constants for the bounded deque with reverse and dedup
// no dependencies; imported by every module of the block

package bdq_pkg;

  // default number of entries
  localparam int unsigned DefaultCapacity = 64;

  // field widths
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 7;

  // command codes
  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REVERSE    = 3'd4,
    CMD_DEDUP      = 3'd5
  } cmd_e;

  // status codes
  typedef enum logic [StatusW-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NO_MATCH = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_DEDUP
  } state_e;

endpackage

### hdl/bdq_store.sv
// bdq_store: entry memory, one write port and one read port, registered read data
// depends on bdq_pkg for the entry width and the default depth

module bdq_store
  import bdq_pkg::*;
#(
  parameter int unsigned Depth = DefaultCapacity,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [ValueW-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [ValueW-1:0] rdata_o
);

  logic [ValueW-1:0] mem_q [Depth];
  logic [ValueW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/bounded_deque_with_reverse_dedup_unit.sv
// bounded_deque_with_reverse_dedup_unit: top level of the bounded deque
// depends on bdq_pkg and bdq_store (entry memory)
//
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+-------------------------------------
// in       | input     | in_valid_i/in_ready_o   | cmd_i, value_i
// out      | output    | out_valid_o/out_ready_i | result_value_o, status_o, entry_count_o
//
// push, reverse and unused codes: result registered in the cycle after the item is taken
// pop: read issued on take, ST_POP registers the result from its data; empty pop as push
// dedup: walks the entries in ST_DEDUP, at most one memory read and one write per cycle
// reset empties the queue at once; the memory contents are not cleared
// an item is taken only when idle and the output register is free or being drained

module bounded_deque_with_reverse_dedup_unit
  import bdq_pkg::*;
#(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [CmdW-1:0]           cmd_i,
  input  logic signed [ValueW-1:0]  value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [ValueW-1:0]  result_value_o,
  output logic [StatusW-1:0]        status_o,
  output logic [CountW-1:0]         entry_count_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam logic [FW:0] CapW  = (FW+1)'(CAPACITY);
  localparam logic [FW-1:0] CapF = FW'(CAPACITY);
  localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);

  // (a + b) mod capacity, both operands below capacity
  function automatic logic [IW-1:0] wrap_add(input logic [FW-1:0] a, input logic [FW-1:0] b);
    logic [FW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= CapW) begin
      s = s - CapW;
    end
    return s[IW-1:0];
  endfunction

  // low bits of the fill count as reported on the output
  function automatic logic [CountW-1:0] to_count(input logic [FW-1:0] f);
    logic [FW+CountW-1:0] e;
    e = (FW+CountW)'(f);
    return e[CountW-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [IW-1:0]       head_q, head_d;
  logic [FW-1:0]       fill_q, fill_d;
  logic                rev_q, rev_d;
  logic [FW-1:0]       rd_q, rd_d;
  logic [FW-1:0]       wr_q, wr_d;
  logic                pend_q, pend_d;
  logic                seen_q, seen_d;
  logic [ValueW-1:0]   val_q, val_d;
  logic                out_valid_q, out_valid_d;
  logic [ValueW-1:0]   res_q, res_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic [CountW-1:0]   count_q, count_d;

  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  logic [ValueW-1:0]   mem_wdata, mem_rdata;

  logic                in_ready;
  logic                in_fire;
  logic [FW-1:0]       head_f;
  logic [IW-1:0]       head_dec;
  logic [FW-1:0]       rd_off, wr_off;

  // entry memory
  bdq_store #(
    .Depth (CAPACITY),
    .AddrW (IW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // address helpers
  assign head_f   = FW'(head_q);
  assign head_dec = (head_q == '0) ? LastIdx : head_q - IW'(1);
  assign rd_off   = rev_q ? fill_q - FW'(1) - rd_q : rd_q;
  assign wr_off   = rev_q ? fill_q - FW'(1) - wr_q : wr_q;

  assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire  = in_valid_i && in_ready;

  // sequencer and datapath
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    rev_d       = rev_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    pend_d      = pend_q;
    seen_d      = seen_q;
    val_d       = val_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    status_d    = status_q;
    count_d     = count_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd_i)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
              out_valid_d = 1'b1;
              res_d       = '0;
              if (fill_q >= CapF) begin
                status_d = STAT_FULL;
                count_d  = to_count(fill_q);
              end else begin
                mem_we    = 1'b1;
                mem_wdata = value_i;
                // back push in reversed order or front push in natural order grows at head
                if ((cmd_i == CMD_PUSH_BACK) == rev_q) begin
                  head_d    = head_dec;
                  mem_waddr = head_dec;
                end else begin
                  mem_waddr = wrap_add(head_f, fill_q);
                end
                fill_d   = fill_q + FW'(1);
                status_d = STAT_OK;
                count_d  = to_count(fill_q + FW'(1));
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (fill_q == '0) begin
                out_valid_d = 1'b1;
                res_d       = '0;
                status_d    = STAT_EMPTY;
                count_d     = to_count(fill_q);
              end else begin
                mem_re = 1'b1;
                if ((cmd_i == CMD_POP_BACK) != rev_q) begin
                  mem_raddr = wrap_add(head_f, fill_q - FW'(1));
                end else begin
                  mem_raddr = head_q;
                  head_d    = wrap_add(head_f, FW'(1));
                end
                fill_d  = fill_q - FW'(1);
                state_d = ST_POP;
              end
            end
            CMD_REVERSE: begin
              rev_d       = !rev_q;
              out_valid_d = 1'b1;
              res_d       = '0;
              status_d    = STAT_OK;
              count_d     = to_count(fill_q);
            end
            CMD_DEDUP: begin
              rd_d    = '0;
              wr_d    = '0;
              pend_d  = 1'b0;
              seen_d  = 1'b0;
              val_d   = value_i;
              state_d = ST_DEDUP;
            end
            default: begin
              out_valid_d = 1'b1;
              res_d       = '0;
              status_d    = STAT_OK;
              count_d     = to_count(fill_q);
            end
          endcase
        end
      end

      ST_POP: begin
        out_valid_d = 1'b1;
        res_d       = mem_rdata;
        status_d    = STAT_OK;
        count_d     = to_count(fill_q);
        state_d     = ST_IDLE;
      end

      ST_DEDUP: begin
        // issue the next read in logical order
        if (rd_q < fill_q) begin
          mem_re    = 1'b1;
          mem_raddr = wrap_add(head_f, rd_off);
          rd_d      = rd_q + FW'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        // compact the entry read last cycle, dropping later copies
        if (pend_q) begin
          if (mem_rdata == val_q) begin
            seen_d = 1'b1;
          end
          if (!((mem_rdata == val_q) && seen_q)) begin
            mem_we    = 1'b1;
            mem_waddr = wrap_add(head_f, wr_off);
            mem_wdata = mem_rdata;
            wr_d      = wr_q + FW'(1);
          end
        end
        // walk done
        if ((rd_q == fill_q) && !pend_q) begin
          fill_d = wr_q;
          if (rev_q) begin
            head_d = wrap_add(head_f, fill_q - wr_q);
          end
          out_valid_d = 1'b1;
          res_d       = '0;
          status_d    = seen_q ? STAT_OK : STAT_NO_MATCH;
          count_d     = to_count(wr_q);
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      rev_q       <= 1'b0;
      rd_q        <= '0;
      wr_q        <= '0;
      pend_q      <= 1'b0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      rev_q       <= rev_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      pend_q      <= pend_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    res_q    <= res_d;
    status_q <= status_d;
    count_q  <= count_d;
  end

  assign in_ready_o     = in_ready;
  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign status_o       = status_q;
  assign entry_count_o  = count_q;

  // fill never exceeds capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CapF)
    else $error("fill count above capacity");

  // compaction write pointer never passes the read pointer
  a_dedup_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEDUP) |-> (wr_q <= rd_q) && (rd_q <= fill_q))
    else $error("dedup pointers out of order");

  // a successful push grows the queue by one
  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (cmd_i == CMD_PUSH_BACK || cmd_i == CMD_PUSH_FRONT) && (fill_q < CapF))
    |=> (fill_q == $past(fill_q) + FW'(1)))
    else $error("push did not grow the queue");

  // a pop in flight always delivers its item next cycle
  a_pop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |=> out_valid_q && (state_q == ST_IDLE))
    else $error("pop result not delivered");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for bounded_deque_with_reverse_dedup_unit
// depends on bdq_pkg and the block's rtl; a deque predictor checks every result item

module tb;
  import bdq_pkg::*;

  localparam int unsigned Capacity    = DefaultCapacity;
  localparam int unsigned ClkHalf     = 4;
  localparam int unsigned MaxReported = 10;
  localparam int unsigned DrainCycles = Capacity + 8;
  localparam int unsigned StallLength = 300;

  // command codes the block ignores
  localparam logic [CmdW-1:0] CmdSpare6 = 3'd6;
  localparam logic [CmdW-1:0] CmdSpare7 = 3'd7;

  typedef logic signed [ValueW-1:0] value_t;

  typedef struct packed {
    value_t              value;
    logic [StatusW-1:0]  status;
    logic [CountW-1:0]   count;
  } deque_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [CmdW-1:0]    cmd_i       = CMD_PUSH_BACK;
  value_t             value_i     = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  value_t             result_value_o;
  logic [StatusW-1:0] status_o;
  logic [CountW-1:0]  entry_count_o;

  // predictor state: occupied entries in physical order plus the direction flag
  value_t        slots_q[$];
  bit            reversed = 1'b0;
  deque_result_t pending_results_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_cycles  = 0;
  int unsigned mismatches    = 0;

  bounded_deque_with_reverse_dedup_unit #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_value_o(result_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // apply one command to the predicted deque and return its result item
  function automatic deque_result_t apply_deque_cmd(logic [CmdW-1:0] c, value_t v);
    deque_result_t r;
    value_t        kept_q[$];
    value_t        x;
    int unsigned   n;
    bit            seen;
    r.value  = '0;
    r.status = STAT_OK;
    n = slots_q.size();
    case (c)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (n >= Capacity) begin
          r.status = STAT_FULL;
        end else if ((c == CMD_PUSH_BACK) != reversed) begin
          slots_q.push_back(v);
        end else begin
          slots_q.push_front(v);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else if ((c == CMD_POP_BACK) != reversed) begin
          r.value = slots_q.pop_back();
        end else begin
          r.value = slots_q.pop_front();
        end
      end
      CMD_REVERSE: begin
        reversed = !reversed;
      end
      CMD_DEDUP: begin
        // walk in logical order, keep the first match and drop later ones
        seen = 1'b0;
        for (int unsigned i = 0; i < n; i++) begin
          x = reversed ? slots_q[n - 1 - i] : slots_q[i];
          if (x != v || !seen) begin
            if (x == v) seen = 1'b1;
            kept_q.push_back(x);
          end
        end
        if (!seen) begin
          r.status = STAT_NO_MATCH;
        end else begin
          slots_q.delete();
          foreach (kept_q[i]) begin
            if (reversed) slots_q.push_front(kept_q[i]);
            else slots_q.push_back(kept_q[i]);
          end
        end
      end
      default: begin
      end
    endcase
    r.count = CountW'(slots_q.size());
    return r;
  endfunction

  // half from a small pool so that dedup finds matches, plus extremes and full range
  function automatic value_t random_value();
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel < 4) return value_t'($urandom_range(6)) - value_t'(3);
    if (sel == 4) return $urandom_range(1) ? value_t'(32'h7fff_ffff) : value_t'(32'h8000_0000);
    return value_t'($urandom());
  endfunction

  // offer one item, hold it until taken, then record its expected result
  task automatic send_cmd(input logic [CmdW-1:0] c, input value_t v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results_q.push_back(apply_deque_cmd(c, v));
  endtask

  // stop offering until every expected result item has come back
  task automatic pause_sender();
    in_valid_i <= 1'b0;
    while (pending_results_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // empty-queue cases, extreme values, every command, dedup with and without a match
  task automatic test_basic_commands();
    send_cmd(CMD_POP_FRONT, 0);
    send_cmd(CMD_POP_BACK, 0);
    send_cmd(CMD_DEDUP, 0);
    send_cmd(CMD_REVERSE, 0);
    send_cmd(CmdSpare6, 32'h1234_5678);
    send_cmd(CmdSpare7, -1);
    send_cmd(CMD_REVERSE, 0);
    send_cmd(CMD_PUSH_BACK, 32'h7fff_ffff);
    send_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
    send_cmd(CMD_PUSH_BACK, 0);
    send_cmd(CMD_PUSH_BACK, -1);
    send_cmd(CMD_PUSH_FRONT, 5);
    send_cmd(CMD_PUSH_BACK, 5);
    send_cmd(CMD_PUSH_BACK, 7);
    send_cmd(CMD_PUSH_BACK, 5);
    send_cmd(CMD_DEDUP, 5);
    send_cmd(CMD_DEDUP, 99);
    send_cmd(CMD_REVERSE, 0);
    send_cmd(CMD_POP_FRONT, 0);
    send_cmd(CMD_POP_BACK, 0);
    send_cmd(CMD_PUSH_FRONT, 5);
    send_cmd(CMD_DEDUP, 5);
    send_cmd(CMD_POP_FRONT, 0);
    send_cmd(CMD_POP_BACK, 0);
  endtask

  // fill to capacity, refused pushes, dedup on a full queue, then drain to empty
  task automatic test_full_queue();
    for (int unsigned pass_no = 0; pass_no < 2; pass_no++) begin
      while (slots_q.size() < Capacity) begin
        send_cmd($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, random_value());
      end
      send_cmd(CMD_PUSH_BACK, 1);
      send_cmd(CMD_PUSH_FRONT, -1);
      send_cmd(CMD_REVERSE, 0);
      send_cmd(CMD_PUSH_BACK, 2);
      send_cmd(CMD_DEDUP, slots_q[$urandom_range(Capacity - 1)]);
    end
    while (slots_q.size() != 0) begin
      send_cmd($urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT, 0);
    end
    send_cmd(CMD_POP_FRONT, 0);
    send_cmd(CMD_POP_BACK, 0);
    pause_sender();
  endtask

  // receiver holds off while items keep coming, so the block backs up
  task automatic test_output_stall();
    stall_cycles = StallLength;
    for (int unsigned k = 0; k < 12; k++) begin
      send_cmd($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, random_value());
    end
    send_cmd(CMD_DEDUP, slots_q[0]);
    pause_sender();
  endtask

  // random command mix steered toward a moving fill target
  task automatic test_random_traffic(input int unsigned count);
    int unsigned     target;
    int unsigned     pick;
    logic [CmdW-1:0] c;
    value_t          v;
    target = 8;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        target = ($urandom_range(3) == 0) ? Capacity + 4 : $urandom_range(Capacity / 2);
      end
      pick = $urandom_range(99);
      v = random_value();
      if (pick < 7) begin
        c = CMD_REVERSE;
      end else if (pick < 17) begin
        c = CMD_DEDUP;
        if (slots_q.size() != 0 && $urandom_range(3) != 0) begin
          v = slots_q[$urandom_range(slots_q.size() - 1)];
        end
      end else if (pick < 19) begin
        c = $urandom_range(1) ? CmdSpare6 : CmdSpare7;
      end else if ((slots_q.size() < target) == ($urandom_range(99) < 75)) begin
        c = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      end else begin
        c = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
      end
      send_cmd(c, v);
    end
  endtask

  // receiver ready, with random idling and an optional long hold-off
  always @(posedge clk_i) begin
    if (stall_cycles != 0) begin
      out_ready_i <= 1'b0;
      stall_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("unexpected item at %0t: value %0d status %0d count %0d",
                   $realtime, result_value_o, status_o, entry_count_o);
        end
      end else begin
        want = pending_results_q.pop_front();
        if (result_value_o !== want.value || status_o !== want.status ||
            entry_count_o !== want.count) begin
          mismatches++;
          if (mismatches <= MaxReported) begin
            $display("mismatch at %0t: expected value %0d status %0d count %0d",
                     $realtime, want.value, want.status, want.count);
            $display("  got value %0d status %0d count %0d",
                     result_value_o, status_o, entry_count_o);
          end
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 16;
    recv_idle_pct = 82;
    test_basic_commands();
    pause_sender();
    test_full_queue();
    test_output_stall();
    test_random_traffic(225);

    send_idle_pct = 82;
    recv_idle_pct = 16;
    test_random_traffic(225);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(225);

    pause_sender();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_results_q.size() == 0) begin
      $display("bounded_deque_with_reverse_dedup_unit test passed");
    end else begin
      $display("bounded_deque_with_reverse_dedup_unit test failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #8000000;
    $display("bounded_deque_with_reverse_dedup_unit test failed");
    $finish;
  end

endmodule

### sim.f
hdl/bdq_pkg.sv
hdl/bdq_store.sv
hdl/bounded_deque_with_reverse_dedup_unit.sv
tb/tb.sv
